>>> hdl/matrix_inverse_2x2_lu_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 2x2 matrix inverse
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_2X2_LU_MACROS_SVH
`define MATRIX_INVERSE_2X2_LU_MACROS_SVH

// same-cycle implication
`define MI2LU_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication
`define MI2LU_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

>>> hdl/mi2lu_pkg.sv
// ----------------------------------------------------------------------------
// mi2lu_pkg
// Widths, status codes, the per-item context and the shared magnitude helper.
// ----------------------------------------------------------------------------
`default_nettype none

package mi2lu_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int THR_W     = 17;
    localparam int DVD_W     = WORD_W + FRAC_BITS;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int SUM_W     = PROD_W - FRAC_BITS + 1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SINGULAR = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [WORD_W-1:0] ONE = WORD_W'(64'd1 << FRAC_BITS);

    typedef struct packed {
        logic                     valid;
        logic                     swp;
        logic [1:0]               status;
        logic signed [WORD_W-1:0] u00;
        logic signed [WORD_W-1:0] u01;
        logic signed [WORD_W-1:0] u11;
        logic signed [WORD_W-1:0] l10;
        logic signed [WORD_W-1:0] x10;
        logic signed [WORD_W-1:0] x11;
    } ctx_t;

    function automatic logic [WORD_W-1:0] mag_w(logic [WORD_W-1:0] x);
        return x[WORD_W-1] ? (~x + 1'b1) : x;
    endfunction

endpackage

`default_nettype wire

>>> hdl/mi2lu_div.sv
// ----------------------------------------------------------------------------
// mi2lu_div
// Two-lane pipelined restoring divider, (num << FRAC_BITS) / den, one
// quotient bit per stage, shared divisor, truncation toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module mi2lu_div import mi2lu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  ctx_t                     ctx_in,
    input  logic signed [WORD_W-1:0] num0,
    input  logic signed [WORD_W-1:0] num1,
    input  logic signed [WORD_W-1:0] den,
    output ctx_t                     ctx_out,
    output logic signed [WORD_W-1:0] q0,
    output logic signed [WORD_W-1:0] q1,
    output logic                     ovf0,
    output logic                     ovf1
);

    typedef struct packed {
        logic [WORD_W-1:0] rem;
        logic [DVD_W-1:0]  dq;
    } lane_t;

    typedef struct packed {
        ctx_t              ctx;
        logic [WORD_W-1:0] dmag;
        logic              dz;
        logic              neg0;
        logic              neg1;
        lane_t             l0;
        lane_t             l1;
    } dstage_t;

    dstage_t st_reg  [0:DVD_W];
    dstage_t st_next [0:DVD_W];

    ctx_t              ctx_out_reg;
    logic [WORD_W:0]   r0_next, r1_next;
    logic [WORD_W-1:0] q0_reg, q1_reg;
    logic              ovf0_reg, ovf1_reg;

    function automatic lane_t div_step(lane_t x, logic [WORD_W-1:0] dmag);
        logic [WORD_W:0] trial;
        logic [WORD_W:0] diff;
        logic            ge;
        lane_t           y;
        trial = {x.rem, x.dq[DVD_W-1]};
        diff  = trial - {1'b0, dmag};
        ge    = trial >= {1'b0, dmag};
        y.rem = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
        y.dq  = {x.dq[DVD_W-2:0], ge};
        return y;
    endfunction

    // {overflow, signed quotient}
    function automatic logic [WORD_W:0] fix_q(logic [DVD_W-1:0] q, logic neg, logic dz);
        logic              hi;
        logic              big;
        logic [WORD_W-1:0] v;
        hi  = |q[DVD_W-1:WORD_W];
        big = neg ? (q[WORD_W-1] && (|q[WORD_W-2:0])) : q[WORD_W-1];
        v   = neg ? (~q[WORD_W-1:0] + 1'b1) : q[WORD_W-1:0];
        return {dz | hi | big, v};
    endfunction

    always_comb
    begin
        st_next[0].ctx     = ctx_in;
        st_next[0].dmag    = mag_w(den);
        st_next[0].dz      = (den == '0);
        st_next[0].neg0    = num0[WORD_W-1] ^ den[WORD_W-1];
        st_next[0].neg1    = num1[WORD_W-1] ^ den[WORD_W-1];
        st_next[0].l0.rem  = '0;
        st_next[0].l0.dq   = {mag_w(num0), {FRAC_BITS{1'b0}}};
        st_next[0].l1.rem  = '0;
        st_next[0].l1.dq   = {mag_w(num1), {FRAC_BITS{1'b0}}};
        for (int k = 1; k <= DVD_W; k++)
        begin
            st_next[k]    = st_reg[k-1];
            st_next[k].l0 = div_step(st_reg[k-1].l0, st_reg[k-1].dmag);
            st_next[k].l1 = div_step(st_reg[k-1].l1, st_reg[k-1].dmag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DVD_W; k++)
            begin
                st_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k <= DVD_W; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign r0_next = fix_q(st_reg[DVD_W].l0.dq, st_reg[DVD_W].neg0, st_reg[DVD_W].dz);
    assign r1_next = fix_q(st_reg[DVD_W].l1.dq, st_reg[DVD_W].neg1, st_reg[DVD_W].dz);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_out_reg <= '0;
            q0_reg      <= '0;
            q1_reg      <= '0;
            ovf0_reg    <= 1'b0;
            ovf1_reg    <= 1'b0;
        end
        else if (en)
        begin
            ctx_out_reg <= st_reg[DVD_W].ctx;
            q0_reg      <= r0_next[WORD_W-1:0];
            q1_reg      <= r1_next[WORD_W-1:0];
            ovf0_reg    <= r0_next[WORD_W];
            ovf1_reg    <= r1_next[WORD_W];
        end
    end

    assign ctx_out = ctx_out_reg;
    assign q0      = q0_reg;
    assign q1      = q1_reg;
    assign ovf0    = ovf0_reg;
    assign ovf1    = ovf1_reg;

endmodule

`default_nettype wire

>>> hdl/mi2lu_msub.sv
// ----------------------------------------------------------------------------
// mi2lu_msub
// Two-lane a - ((b * c) >>> FRAC_BITS) with word range check, two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mi2lu_msub import mi2lu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  ctx_t                     ctx_in,
    input  logic signed [WORD_W-1:0] a0,
    input  logic signed [WORD_W-1:0] b0,
    input  logic signed [WORD_W-1:0] c0,
    input  logic signed [WORD_W-1:0] a1,
    input  logic signed [WORD_W-1:0] b1,
    input  logic signed [WORD_W-1:0] c1,
    output ctx_t                     ctx_out,
    output logic signed [WORD_W-1:0] r0,
    output logic signed [WORD_W-1:0] r1,
    output logic                     ovf0,
    output logic                     ovf1
);

    ctx_t                     ctx1_reg, ctx2_reg;
    logic signed [WORD_W-1:0] a0_reg, a1_reg;
    logic signed [PROD_W-1:0] p0_reg, p1_reg;
    logic signed [SUM_W-1:0]  s0_next, s1_next;
    logic signed [WORD_W-1:0] r0_reg, r1_reg;
    logic                     ovf0_reg, ovf1_reg;

    // stage 1: full products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg <= a0;
            a1_reg <= a1;
            p0_reg <= PROD_W'(b0) * PROD_W'(c0);
            p1_reg <= PROD_W'(b1) * PROD_W'(c1);
        end
    end

    // stage 2: floor shift, subtract, range check
    assign s0_next = SUM_W'(a0_reg) - SUM_W'(p0_reg >>> FRAC_BITS);
    assign s1_next = SUM_W'(a1_reg) - SUM_W'(p1_reg >>> FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r0_reg   <= s0_next[WORD_W-1:0];
            r1_reg   <= s1_next[WORD_W-1:0];
            ovf0_reg <= !((&s0_next[SUM_W-1:WORD_W-1]) || !(|s0_next[SUM_W-1:WORD_W-1]));
            ovf1_reg <= !((&s1_next[SUM_W-1:WORD_W-1]) || !(|s1_next[SUM_W-1:WORD_W-1]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx1_reg <= '0;
            ctx2_reg <= '0;
        end
        else if (en)
        begin
            ctx1_reg <= ctx_in;
            ctx2_reg <= ctx1_reg;
        end
    end

    assign ctx_out = ctx2_reg;
    assign r0      = r0_reg;
    assign r1      = r1_reg;
    assign ovf0    = ovf0_reg;
    assign ovf1    = ovf1_reg;

endmodule

`default_nettype wire

>>> hdl/matrix_inverse_2x2_lu.sv
// ----------------------------------------------------------------------------
// matrix_inverse_2x2_lu
// Structure: three 50-stage dividers (one quotient bit per stage) plus
//   two 2-stage multiply units.
// Throughput: one matrix per cycle; the whole pipe holds while a result
//   beat is stalled.
// Reset: asynchronous, clears all valid bits; pivot_threshold resets to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_inverse_2x2_lu import mi2lu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [THR_W-1:0]         cfg_wr_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [WORD_W-1:0] a00,
    input  logic signed [WORD_W-1:0] a01,
    input  logic signed [WORD_W-1:0] a10,
    input  logic signed [WORD_W-1:0] a11,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [WORD_W-1:0] inv00,
    output logic signed [WORD_W-1:0] inv01,
    output logic signed [WORD_W-1:0] inv10,
    output logic signed [WORD_W-1:0] inv11,
    output logic [1:0]               status
);

    logic [THR_W-1:0]  pivot_threshold_reg;
    logic [WORD_W-1:0] thr;
    logic              en;

    ctx_t front_reg, front_next;
    ctx_t d1_ctx, ma_in, ma_ctx, mid_reg, mid_next;
    ctx_t d2_ctx, mb_in, mb_ctx, d3_in, d3_ctx, fin;

    logic signed [WORD_W-1:0] d1_q0, d2_q0, d2_q1, d3_q0, d3_q1;
    logic signed [WORD_W-1:0] ma_r0, mb_r0, mb_r1;
    logic                     d1_ovf0, d2_ovf0, d2_ovf1, d3_ovf0, d3_ovf1;
    logic                     ma_ovf0, mb_ovf0, mb_ovf1;
    logic [WORD_W-1:0]        mag00, mag10, mag_u00;
    logic [WORD_W-1:0]        pc0, pc1;
    logic signed [WORD_W:0]   y0, y1;

    logic                     out_valid_reg;
    logic [1:0]               status_reg;
    logic signed [WORD_W-1:0] inv00_reg, inv01_reg, inv10_reg, inv11_reg;

    // the first failure wins; later flags only matter while still ok
    function automatic logic [1:0] upd(logic [1:0] st, logic ovf);
        return (ovf && (st == ST_OK)) ? ST_OVERFLOW : st;
    endfunction

    // the pipe advances as one whenever the result register can move
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // configuration; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pivot_threshold_reg <= THR_W'(1);
        end
        else if (cfg_wr_en)
        begin
            pivot_threshold_reg <= cfg_wr_data;
        end
    end

    assign thr = {{(WORD_W-THR_W){1'b0}}, pivot_threshold_reg};

    // front: partial pivot and first pivot test
    always_comb
    begin
        mag00            = mag_w(a00);
        mag10            = mag_w(a10);
        front_next       = '0;
        front_next.valid = in_valid;
        front_next.swp   = (mag00 < thr) && (mag10 > thr);
        front_next.u00   = front_next.swp ? a10 : a00;
        front_next.u01   = front_next.swp ? a11 : a01;
        front_next.u11   = front_next.swp ? a01 : a11;
        // l10 carries the lower pivot-column element until the first divide
        front_next.l10   = front_next.swp ? a00 : a10;
        mag_u00          = mag_w(front_next.u00);
        front_next.status = (mag_u00 < thr) ? ST_SINGULAR : ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
        end
        else if (en)
        begin
            front_reg <= front_next;
        end
    end

    // multiplier l10 = u10 / u00
    mi2lu_div u_div1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctx_in  (front_reg),
        .num0    (front_reg.l10),
        .num1    ('0),
        .den     (front_reg.u00),
        .ctx_out (d1_ctx),
        .q0      (d1_q0),
        .q1      (),
        .ovf0    (d1_ovf0),
        .ovf1    ()
    );

    always_comb
    begin
        ma_in        = d1_ctx;
        ma_in.status = upd(d1_ctx.status, d1_ovf0);
        ma_in.l10    = d1_q0;
    end

    // updated pivot u11 - l10 * u01; second lane idle
    mi2lu_msub u_msub_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctx_in  (ma_in),
        .a0      (ma_in.u11),
        .b0      (ma_in.l10),
        .c0      (ma_in.u01),
        .a1      ('0),
        .b1      ('0),
        .c1      ('0),
        .ctx_out (ma_ctx),
        .r0      (ma_r0),
        .r1      (),
        .ovf0    (ma_ovf0),
        .ovf1    ()
    );

    // mid: second pivot test and forward substitution; the product of l10
    // with a unit permutation entry is l10 itself, so no multiplier here
    always_comb
    begin
        pc0 = ma_ctx.swp ? '0 : ONE;
        pc1 = ma_ctx.swp ? ONE : '0;
        y0  = {pc1[WORD_W-1], pc1} - ((pc0 != '0) ? {ma_ctx.l10[WORD_W-1], ma_ctx.l10} : '0);
        y1  = {pc0[WORD_W-1], pc0} - ((pc1 != '0) ? {ma_ctx.l10[WORD_W-1], ma_ctx.l10} : '0);
        mid_next        = ma_ctx;
        mid_next.u11    = ma_r0;
        mid_next.status = upd(ma_ctx.status, ma_ovf0);
        if ((mid_next.status == ST_OK) && (mag_w(ma_r0) < thr))
        begin
            mid_next.status = ST_SINGULAR;
        end
        mid_next.status = upd(mid_next.status,
                              (y0[WORD_W] != y0[WORD_W-1]) || (y1[WORD_W] != y1[WORD_W-1]));
        // x10/x11 hold the forward values until the second divide
        mid_next.x10    = y0[WORD_W-1:0];
        mid_next.x11    = y1[WORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg <= '0;
        end
        else if (en)
        begin
            mid_reg <= mid_next;
        end
    end

    // bottom row of the inverse: y / u11
    mi2lu_div u_div2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctx_in  (mid_reg),
        .num0    (mid_reg.x10),
        .num1    (mid_reg.x11),
        .den     (mid_reg.u11),
        .ctx_out (d2_ctx),
        .q0      (d2_q0),
        .q1      (d2_q1),
        .ovf0    (d2_ovf0),
        .ovf1    (d2_ovf1)
    );

    always_comb
    begin
        mb_in        = d2_ctx;
        mb_in.status = upd(d2_ctx.status, d2_ovf0 || d2_ovf1);
        mb_in.x10    = d2_q0;
        mb_in.x11    = d2_q1;
    end

    // back substitution numerators p[c] - u01 * x[2+c]
    mi2lu_msub u_msub_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctx_in  (mb_in),
        .a0      (mb_in.swp ? '0 : ONE),
        .b0      (mb_in.u01),
        .c0      (mb_in.x10),
        .a1      (mb_in.swp ? ONE : '0),
        .b1      (mb_in.u01),
        .c1      (mb_in.x11),
        .ctx_out (mb_ctx),
        .r0      (mb_r0),
        .r1      (mb_r1),
        .ovf0    (mb_ovf0),
        .ovf1    (mb_ovf1)
    );

    always_comb
    begin
        d3_in        = mb_ctx;
        d3_in.status = upd(mb_ctx.status, mb_ovf0 || mb_ovf1);
    end

    // top row of the inverse: t / u00
    mi2lu_div u_div3 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctx_in  (d3_in),
        .num0    (mb_r0),
        .num1    (mb_r1),
        .den     (d3_in.u00),
        .ctx_out (d3_ctx),
        .q0      (d3_q0),
        .q1      (d3_q1),
        .ovf0    (d3_ovf0),
        .ovf1    (d3_ovf1)
    );

    always_comb
    begin
        fin        = d3_ctx;
        fin.status = upd(d3_ctx.status, d3_ovf0 || d3_ovf1);
    end

    // result register: hold while stalled, zero the matrix on any failure
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            inv00_reg     <= '0;
            inv01_reg     <= '0;
            inv10_reg     <= '0;
            inv11_reg     <= '0;
        end
        else if (en)
        begin
            out_valid_reg <= fin.valid;
            status_reg    <= fin.status;
            inv00_reg     <= (fin.status == ST_OK) ? d3_q0   : '0;
            inv01_reg     <= (fin.status == ST_OK) ? d3_q1   : '0;
            inv10_reg     <= (fin.status == ST_OK) ? fin.x10 : '0;
            inv11_reg     <= (fin.status == ST_OK) ? fin.x11 : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign inv00     = inv00_reg;
    assign inv01     = inv01_reg;
    assign inv10     = inv10_reg;
    assign inv11     = inv11_reg;

endmodule

`default_nettype wire

>>> hdl/mi2lu_chk.sv
// ----------------------------------------------------------------------------
// mi2lu_chk
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "matrix_inverse_2x2_lu_macros.svh"

module mi2lu_chk import mi2lu_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic signed [WORD_W-1:0] inv00,
    input logic signed [WORD_W-1:0] inv01,
    input logic signed [WORD_W-1:0] inv10,
    input logic signed [WORD_W-1:0] inv11,
    input logic [1:0]               status
);

    `MI2LU_AST_NXT(a_hold_valid, out_valid && out_stall, out_valid)
    `MI2LU_AST_NXT(a_hold_beat, out_valid && out_stall, $stable(inv00) && $stable(inv11) && $stable(status))
    `MI2LU_AST_IMP(a_fail_zero, out_valid && (status != ST_OK), (inv00 == 0) && (inv01 == 0) && (inv10 == 0) && (inv11 == 0))
    `MI2LU_AST_IMP(a_status_code, out_valid, (status == ST_OK) || (status == ST_SINGULAR) || (status == ST_OVERFLOW))
    `MI2LU_AST_IMP(a_stall_path, 1'b1, in_stall == (out_valid && out_stall))

endmodule

bind matrix_inverse_2x2_lu mi2lu_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .inv00     (inv00),
    .inv01     (inv01),
    .inv10     (inv10),
    .inv11     (inv11),
    .status    (status)
);

`default_nettype wire
